// ===== src/sscu_pkg.sv =====
// Package for the sample sequence unwrap/classify core.
// Holds the result kind codes, field widths and the register map.
package sscu_pkg;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned FINE_W   = 32;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned MISSED_W = 15;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_BRIDGE_LIMIT = 3'h0;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRST        = 3'd0,
    KIND_DUPLICATE    = 3'd1,
    KIND_OUT_OF_ORDER = 3'd2,
    KIND_NEXT         = 3'd3,
    KIND_GAP          = 3'd4,
    KIND_RESTART      = 3'd5
  } kind_e;

endpackage

// ===== src/sample_sequence_unwrap_classify_core.sv =====
// Sample sequence unwrap/classify core: top level.
// Depends on sscu_pkg for kind codes, widths and the register map.

// One item per clock sustained while the result channel is not stalled: an item
// waits in the input register, is classified and unwrapped by 16-bit and 32-bit
// subtracts, compares and two TOTAL_WIDTH-bit adds, and lands in the result
// register. The running state (last counter, last timestamp, extended totals)
// is written at the same edge as the result for items that update it, so the
// next item in the input register always sees it. bridge_limit sits at
// byte address 0; write it only while no item is in flight.
module sample_sequence_unwrap_classify_core #(
  parameter int unsigned TOTAL_WIDTH = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sscu_pkg::PADDR_W-1:0]      paddr,
  input  logic [sscu_pkg::PDATA_W-1:0]      pwdata,
  output logic [sscu_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sscu_pkg::COUNT_W-1:0]      seq_count_i,
  input  logic [sscu_pkg::FINE_W-1:0]       fine_time_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sscu_pkg::KIND_W-1:0]       kind_o,
  output logic [sscu_pkg::OUT_W-1:0]        sample_index_o,
  output logic [sscu_pkg::OUT_W-1:0]        tick_total_o,
  output logic [sscu_pkg::MISSED_W-1:0]     missed_o
);
  import sscu_pkg::*;

  localparam int unsigned TW = TOTAL_WIDTH;

  // config
  logic [MISSED_W-1:0] bridge_limit_q;
  logic                cfg_wr;

  // input register
  logic                s1_valid_q;
  logic [COUNT_W-1:0]  seq_q;
  logic [FINE_W-1:0]   fine_q;

  // running state
  logic                seen_any_q;
  logic [COUNT_W-1:0]  prev_count_q;
  logic [FINE_W-1:0]   prev_time_q;
  logic [TW-1:0]       index_total_q, index_total_d;
  logic [TW-1:0]       time_total_q, time_total_d;

  // result register
  logic                out_valid_q;
  kind_e               kind_q, kind_d;
  logic [OUT_W-1:0]    index_out_q, index_out_d;
  logic [OUT_W-1:0]    tick_out_q, tick_out_d;
  logic [MISSED_W-1:0] missed_q, missed_d;

  logic                in_acc;
  logic                s1_adv;
  logic [COUNT_W-1:0]  step;
  logic [FINE_W-1:0]   fine_delta;
  logic [COUNT_W-1:0]  step_m1;
  logic                is_first, is_dup, is_ooo, upd;
  logic [63:0]         index_wide, time_wide;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_BRIDGE_LIMIT[2]);
  assign prdata = (paddr[2] == ADDR_BRIDGE_LIMIT[2]) ?
                  {{(PDATA_W-MISSED_W){1'b0}}, bridge_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bridge_limit_q <= '0;
    end else if (cfg_wr) begin
      bridge_limit_q <= pwdata[MISSED_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q  <= seq_count_i;
      fine_q <= fine_time_i;
    end
  end

  // ---------------- classify and unwrap ----------------
  always_comb begin
    step       = seq_q - prev_count_q;
    fine_delta = fine_q - prev_time_q;
    step_m1    = step - COUNT_W'(1);
    is_first   = !seen_any_q;
    is_dup     = (step == '0);
    is_ooo     = step[COUNT_W-1];   // modular step of 0x8000 or more
    upd        = is_first || (!is_dup && !is_ooo);

    index_total_d = index_total_q;
    time_total_d  = time_total_q;
    missed_d      = '0;
    kind_d        = KIND_FIRST;

    priority if (is_first) begin
      index_total_d = {{(TW-COUNT_W){1'b0}}, seq_q};
      time_total_d  = {{(TW-FINE_W){1'b0}}, fine_q};
      kind_d        = KIND_FIRST;
    end else if (is_dup) begin
      kind_d = KIND_DUPLICATE;
    end else if (is_ooo) begin
      kind_d = KIND_OUT_OF_ORDER;
    end else begin
      index_total_d = index_total_q + {{(TW-COUNT_W){1'b0}}, step};
      time_total_d  = time_total_q + {{(TW-FINE_W){1'b0}}, fine_delta};
      if (step == COUNT_W'(1)) begin
        kind_d = KIND_NEXT;
      end else begin
        missed_d = step_m1[MISSED_W-1:0];
        kind_d   = (step_m1[MISSED_W-1:0] <= bridge_limit_q) ? KIND_GAP : KIND_RESTART;
      end
    end

    index_wide  = 64'(index_total_d);
    time_wide   = 64'(time_total_d);
    index_out_d = index_wide[OUT_W-1:0];
    tick_out_d  = time_wide[OUT_W-1:0];
  end

  // ---------------- state and result registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_any_q    <= 1'b0;
      prev_count_q  <= '0;
      prev_time_q   <= '0;
      index_total_q <= '0;
      time_total_q  <= '0;
    end else if (s1_adv && upd) begin
      seen_any_q    <= 1'b1;
      prev_count_q  <= seq_q;
      prev_time_q   <= fine_q;
      index_total_q <= index_total_d;
      time_total_q  <= time_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      kind_q      <= kind_d;
      index_out_q <= index_out_d;
      tick_out_q  <= tick_out_d;
      missed_q    <= missed_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign sample_index_o = index_out_q;
  assign tick_total_o   = tick_out_q;
  assign missed_o       = missed_q;

`ifndef SYNTHESIS
  a_missed_only_on_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && missed_o != '0) |-> (kind_o == KIND_GAP || kind_o == KIND_RESTART))
    else $error("missed count on a result that skipped nothing");

  a_first_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !seen_any_q) |=> seen_any_q)
    else $error("first item did not mark the stream as started");

  a_dup_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && seen_any_q && (is_dup || is_ooo)) |=>
      ($stable(index_total_q) && $stable(time_total_q) && $stable(prev_count_q)))
    else $error("duplicate or out-of-order item changed the running state");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline slot");
`endif

endmodule
